// ===== hw/rtl/ata_pkg.sv =====
// Shared types and constants of the audio timeline aligner.
// Used by ata_muldiv, audio_timeline_aligner_unit, ata_checker and tb_top; depends on nothing.
package ata_pkg;

    // Timeline ticks per second (100 ns units)
    localparam logic [23:0] TICKS_PER_SEC = 24'd10_000_000;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_FRAME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMELINE_START  = 2'd2;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [17:0] RST_SAMPLE_RATE     = 18'd48000;
    localparam logic [6:0]  RST_BYTES_PER_FRAME = 7'd4;
    localparam logic [63:0] RST_TIMELINE_START  = 64'd0;

    typedef enum logic [1:0] {
        ST_WRITTEN = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_STALE   = 2'd2,
        ST_TRIMMED = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [63:0] packet_time;
        logic [19:0]        frame_count;
        logic [25:0]        byte_count;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [31:0]        silence_frames;
        logic [19:0]        skip_frames;
        logic [25:0]        write_bytes;
        logic signed [63:0] timeline_next;
    } t_out_item;

    // Shared multiply-divide unit: floor(a * b / c)
    localparam int unsigned MD_A_W      = 64;
    localparam int unsigned MD_B_W      = 24;
    localparam int unsigned MD_C_W      = 24;
    localparam int unsigned MD_P_W      = MD_A_W + MD_B_W;
    localparam int unsigned MD_CHUNK    = 16;
    localparam int unsigned MD_CHUNKS   = MD_A_W / MD_CHUNK;
    localparam int unsigned MD_NBITS_W  = 7;
    localparam int unsigned MD_CNT_W    = 6;

    // Significant product widths per operation (all even)
    localparam logic [MD_NBITS_W-1:0] N_DUR  = 7'd44;
    localparam logic [MD_NBITS_W-1:0] N_GAP  = 7'd82;
    localparam logic [MD_NBITS_W-1:0] N_ADV1 = 7'd56;
    localparam logic [MD_NBITS_W-1:0] N_SKIP = 7'd82;
    localparam logic [MD_NBITS_W-1:0] N_FRM  = 7'd26;
    localparam logic [MD_NBITS_W-1:0] N_ADV2 = 7'd50;

    typedef struct packed {
        logic                  start;
        logic [MD_A_W-1:0]     a;
        logic [MD_B_W-1:0]     b;
        logic [MD_C_W-1:0]     c;
        logic [MD_NBITS_W-1:0] nbits;
    } t_md_req;

    typedef struct packed {
        logic              done;
        logic [MD_P_W-1:0] quot;
        logic              rem_nz;
    } t_md_rsp;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_ALIGN,
        MD_DIV,
        MD_DONE
    } t_md_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_RUN,
        S_SIZE,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_DUR,
        OP_GAP,
        OP_ADV1,
        OP_SKIP,
        OP_FRM,
        OP_ADV2
    } t_op;

endpackage

// ===== hw/rtl/audio_timeline_aligner_unit.sv =====
// Audio timeline aligner: places packet headers on a 100 ns timeline; needs ata_pkg, ata_muldiv.
// Empty packets and zero rate or frame size go straight to the result; a stale packet ends after
// the duration pass; others run gap and advance, or skip, then sizing and, unless trimmed, frame and advance.
// One packet at a time: input stalls until the result transfer, then the unit returns to idle.
// Each shared multiply-divide pass runs multiply, align and divide steps over 26 to 82 product bits.
// Reset (synchronous, active low) clears position and started flag, restores register defaults.
module audio_timeline_aligner_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ata_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ata_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  ata_pkg::t_in_item                 i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output ata_pkg::t_out_item                o_out
);

    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

    ata_pkg::t_state r_state, n_state;
    ata_pkg::t_op    r_op, n_op;
    ata_pkg::t_status r_status, n_status;

    logic [17:0]        r_sample_rate;
    logic [6:0]         r_bytes_per_frame;
    logic [63:0]        r_timeline_start;

    logic signed [63:0] r_np, n_np;
    logic               r_started, n_started;
    logic signed [63:0] r_pt, n_pt;
    logic [19:0]        r_fc, n_fc;
    logic [25:0]        r_bc, n_bc;
    logic               r_gap, n_gap;
    logic [63:0]        r_diff, n_diff;
    logic [31:0]        r_silence, n_silence;
    logic [19:0]        r_skip, n_skip;
    logic [25:0]        r_wbytes, n_wbytes;

    ata_pkg::t_md_req md_req;
    ata_pkg::t_md_rsp md_rsp;

    logic [63:0] pt_minus_np, np_minus_pt;
    logic [26:0] off, avail;
    logic [25:0] rest, size_bytes;
    logic        trim, q_big_skip;

    ata_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    function automatic ata_pkg::t_md_req f_launch(
        input logic [ata_pkg::MD_A_W-1:0]     a,
        input logic [ata_pkg::MD_B_W-1:0]     b,
        input logic [ata_pkg::MD_C_W-1:0]     c,
        input logic [ata_pkg::MD_NBITS_W-1:0] nbits
    );
        ata_pkg::t_md_req req;
        req.start = 1'b1;
        req.a     = a;
        req.b     = b;
        req.c     = c;
        req.nbits = nbits;
        return req;
    endfunction

    // Advance a signed position, saturating at the largest value
    function automatic logic [63:0] f_advance(
        input logic [63:0] pos,
        input logic [63:0] amount
    );
        logic [64:0] sum;
        sum = {1'b0, pos ^ SIGN_BIT} + {1'b0, amount};
        if (sum[64]) begin
            sum[63:0] = '1;
        end
        return sum[63:0] ^ SIGN_BIT;
    endfunction

    assign pt_minus_np = 64'(r_pt - r_np);
    assign np_minus_pt = 64'(r_np - r_pt);

    assign off        = 27'(r_skip * r_bytes_per_frame);
    assign avail      = 27'((r_fc - r_skip) * r_bytes_per_frame);
    assign trim       = (r_skip >= r_fc) || (off >= {1'b0, r_bc});
    assign rest       = r_bc - off[25:0];
    assign size_bytes = (avail < {1'b0, rest}) ? avail[25:0] : rest;

    assign q_big_skip = (|md_rsp.quot[ata_pkg::MD_P_W-1:20]) || (md_rsp.quot[19:0] >= r_fc);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_status  = r_status;
        n_np      = r_np;
        n_started = r_started;
        n_pt      = r_pt;
        n_fc      = r_fc;
        n_bc      = r_bc;
        n_gap     = r_gap;
        n_diff    = r_diff;
        n_silence = r_silence;
        n_skip    = r_skip;
        n_wbytes  = r_wbytes;
        md_req    = '0;
        unique case (r_state)
            ata_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_pt      = i_in.packet_time;
                    n_fc      = i_in.frame_count;
                    n_bc      = i_in.byte_count;
                    n_status  = ata_pkg::ST_WRITTEN;
                    n_silence = '0;
                    n_skip    = '0;
                    n_wbytes  = '0;
                    if (i_in.frame_count == '0 || i_in.byte_count == '0) begin
                        n_status = ata_pkg::ST_EMPTY;
                        n_state  = ata_pkg::S_OUT;
                    end else begin
                        // Seed the position on the first non-empty packet
                        if (!r_started) begin
                            n_np      = r_timeline_start;
                            n_started = 1'b1;
                        end
                        if (r_sample_rate == '0 || r_bytes_per_frame == '0) begin
                            n_status = ata_pkg::ST_EMPTY;
                            n_state  = ata_pkg::S_OUT;
                        end else begin
                            n_state = ata_pkg::S_PREP;
                        end
                    end
                end
            end
            ata_pkg::S_PREP: begin
                n_gap   = (r_pt > r_np);
                n_diff  = (r_pt > r_np) ? pt_minus_np : np_minus_pt;
                md_req  = f_launch(64'(r_fc), ata_pkg::TICKS_PER_SEC, 24'(r_sample_rate),
                                   ata_pkg::N_DUR);
                n_op    = ata_pkg::OP_DUR;
                n_state = ata_pkg::S_RUN;
            end
            ata_pkg::S_RUN: begin
                if (md_rsp.done) begin
                    unique case (r_op)
                        ata_pkg::OP_DUR: begin
                            if (!r_gap && (64'(md_rsp.quot[ata_pkg::N_DUR-1:0]) <= r_diff)) begin
                                n_status = ata_pkg::ST_STALE;
                                n_state  = ata_pkg::S_OUT;
                            end else if (r_gap) begin
                                md_req = f_launch(r_diff, 24'(r_sample_rate),
                                                  ata_pkg::TICKS_PER_SEC, ata_pkg::N_GAP);
                                n_op   = ata_pkg::OP_GAP;
                            end else if (r_diff != '0) begin
                                md_req = f_launch(r_diff, 24'(r_sample_rate),
                                                  ata_pkg::TICKS_PER_SEC, ata_pkg::N_SKIP);
                                n_op   = ata_pkg::OP_SKIP;
                            end else begin
                                n_state = ata_pkg::S_SIZE;
                            end
                        end
                        ata_pkg::OP_GAP: begin
                            // Saturate the silence count at 32 bits
                            n_silence = (|md_rsp.quot[ata_pkg::MD_P_W-1:32]) ? '1
                                      : md_rsp.quot[31:0];
                            md_req    = f_launch(64'(n_silence), ata_pkg::TICKS_PER_SEC,
                                                 24'(r_sample_rate), ata_pkg::N_ADV1);
                            n_op      = ata_pkg::OP_ADV1;
                        end
                        ata_pkg::OP_ADV1: begin
                            // The advance never passes the packet start, so no overlap follows
                            n_np    = f_advance(r_np,
                                                64'(md_rsp.quot[ata_pkg::N_ADV1-1:0]));
                            n_state = ata_pkg::S_SIZE;
                        end
                        ata_pkg::OP_SKIP: begin
                            // Round up, bounded by the packet's frames
                            n_skip  = q_big_skip ? r_fc
                                    : md_rsp.quot[19:0] + 20'(md_rsp.rem_nz);
                            n_state = ata_pkg::S_SIZE;
                        end
                        ata_pkg::OP_FRM: begin
                            md_req = f_launch(64'(md_rsp.quot[ata_pkg::N_FRM-1:0]),
                                              ata_pkg::TICKS_PER_SEC, 24'(r_sample_rate),
                                              ata_pkg::N_ADV2);
                            n_op   = ata_pkg::OP_ADV2;
                        end
                        ata_pkg::OP_ADV2: begin
                            n_np    = f_advance(r_np,
                                                64'(md_rsp.quot[ata_pkg::N_ADV2-1:0]));
                            n_state = ata_pkg::S_OUT;
                        end
                        default: n_state = ata_pkg::S_OUT;
                    endcase
                end
            end
            ata_pkg::S_SIZE: begin
                if (trim) begin
                    n_status  = ata_pkg::ST_TRIMMED;
                    n_silence = '0;
                    n_state   = ata_pkg::S_OUT;
                end else begin
                    n_wbytes = size_bytes;
                    md_req   = f_launch(64'(size_bytes), 24'd1, 24'(r_bytes_per_frame),
                                        ata_pkg::N_FRM);
                    n_op     = ata_pkg::OP_FRM;
                    n_state  = ata_pkg::S_RUN;
                end
            end
            ata_pkg::S_OUT: begin
                if (!i_out_stall) begin
                    n_state = ata_pkg::S_IDLE;
                end
            end
            default: n_state = ata_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ata_pkg::S_IDLE;
            r_np              <= '0;
            r_started         <= 1'b0;
            r_sample_rate     <= ata_pkg::RST_SAMPLE_RATE;
            r_bytes_per_frame <= ata_pkg::RST_BYTES_PER_FRAME;
            r_timeline_start  <= ata_pkg::RST_TIMELINE_START;
        end else begin
            r_state   <= n_state;
            r_np      <= n_np;
            r_started <= n_started;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    ata_pkg::CFG_SAMPLE_RATE:     r_sample_rate     <= i_cfg_data[17:0];
                    ata_pkg::CFG_BYTES_PER_FRAME: r_bytes_per_frame <= i_cfg_data[6:0];
                    ata_pkg::CFG_TIMELINE_START:  r_timeline_start  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_status  <= n_status;
        r_pt      <= n_pt;
        r_fc      <= n_fc;
        r_bc      <= n_bc;
        r_gap     <= n_gap;
        r_diff    <= n_diff;
        r_silence <= n_silence;
        r_skip    <= n_skip;
        r_wbytes  <= n_wbytes;
    end

    assign o_in_stall  = (r_state != ata_pkg::S_IDLE);
    assign o_out_valid = (r_state == ata_pkg::S_OUT);

    assign o_out.status         = r_status;
    assign o_out.silence_frames = r_silence;
    assign o_out.skip_frames    = r_skip;
    assign o_out.write_bytes    = r_wbytes;
    assign o_out.timeline_next  = r_np;

    // A written packet always carries payload
    a_written_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ata_pkg::ST_WRITTEN) |-> (o_out.write_bytes != '0))
        else $error("written result with no payload bytes");

    // A dropped packet asks for no silence and writes nothing
    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ata_pkg::ST_WRITTEN)
            |-> (o_out.silence_frames == '0 && o_out.write_bytes == '0))
        else $error("dropped result with silence or payload");

    // The shared unit only finishes while the sequencer waits on it
    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_rsp.done |-> (r_state == ata_pkg::S_RUN))
        else $error("multiply-divide result outside the run state");

    // The position moves only on a transfer in or while the sequencer works
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ata_pkg::S_OUT) |=> $stable(r_np))
        else $error("position changed while a result waits");

endmodule

// ===== hw/rtl/ata_muldiv.sv =====
// Shared serial multiply-divide unit: quotient and remainder flag of a * b / c.
// Multiplies 16 bits of a per cycle, divides two quotient bits per cycle.
// Depends on ata_pkg.
module ata_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ata_pkg::t_md_req i_req,
    output ata_pkg::t_md_rsp o_rsp
);

    ata_pkg::t_md_state r_state, n_state;
    logic [ata_pkg::MD_CNT_W-1:0]   r_cnt, n_cnt;
    logic [ata_pkg::MD_CNT_W-1:0]   r_half, n_half;
    logic [ata_pkg::MD_NBITS_W-1:0] r_shamt, n_shamt;
    logic [ata_pkg::MD_A_W-1:0]     r_a, n_a;
    logic [ata_pkg::MD_B_W-1:0]     r_b, n_b;
    logic [ata_pkg::MD_C_W-1:0]     r_c, n_c;
    logic [ata_pkg::MD_P_W-1:0]     r_acc, n_acc;
    logic [ata_pkg::MD_C_W-1:0]     r_rem, n_rem;

    logic [ata_pkg::MD_CHUNK+ata_pkg::MD_B_W-1:0] mul_part;
    logic [ata_pkg::MD_C_W:0]   t1, t2, d1, d2;
    logic                       ge1, ge2;
    logic [ata_pkg::MD_C_W-1:0] rem1, rem2;
    logic [ata_pkg::MD_P_W-1:0] acc1, acc2;

    assign mul_part = r_a[ata_pkg::MD_A_W-1 -: ata_pkg::MD_CHUNK] * r_b;

    // Two restoring divide steps per cycle
    always_comb begin
        t1   = {r_rem, r_acc[ata_pkg::MD_P_W-1]};
        d1   = t1 - {1'b0, r_c};
        ge1  = (t1 >= {1'b0, r_c});
        rem1 = ge1 ? d1[ata_pkg::MD_C_W-1:0] : t1[ata_pkg::MD_C_W-1:0];
        acc1 = {r_acc[ata_pkg::MD_P_W-2:0], ge1};
        t2   = {rem1, acc1[ata_pkg::MD_P_W-1]};
        d2   = t2 - {1'b0, r_c};
        ge2  = (t2 >= {1'b0, r_c});
        rem2 = ge2 ? d2[ata_pkg::MD_C_W-1:0] : t2[ata_pkg::MD_C_W-1:0];
        acc2 = {acc1[ata_pkg::MD_P_W-2:0], ge2};
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_half  = r_half;
        n_shamt = r_shamt;
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_acc   = r_acc;
        n_rem   = r_rem;
        unique case (r_state)
            ata_pkg::MD_IDLE, ata_pkg::MD_DONE: begin
                n_state = ata_pkg::MD_IDLE;
                if (i_req.start) begin
                    n_a     = i_req.a;
                    n_b     = i_req.b;
                    n_c     = i_req.c;
                    n_acc   = '0;
                    n_rem   = '0;
                    n_cnt   = ata_pkg::MD_CNT_W'(ata_pkg::MD_CHUNKS - 1);
                    n_half  = i_req.nbits[ata_pkg::MD_NBITS_W-1:1] - 1'b1;
                    n_shamt = ata_pkg::MD_NBITS_W'(ata_pkg::MD_P_W) - i_req.nbits;
                    n_state = ata_pkg::MD_MUL;
                end
            end
            ata_pkg::MD_MUL: begin
                // Accumulate from the top chunk of a down
                n_acc = {r_acc[ata_pkg::MD_P_W-ata_pkg::MD_CHUNK-1:0],
                         {ata_pkg::MD_CHUNK{1'b0}}}
                      + ata_pkg::MD_P_W'(mul_part);
                n_a   = {r_a[ata_pkg::MD_A_W-ata_pkg::MD_CHUNK-1:0],
                         {ata_pkg::MD_CHUNK{1'b0}}};
                if (r_cnt == '0) begin
                    n_state = ata_pkg::MD_ALIGN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ata_pkg::MD_ALIGN: begin
                // Left-align the significant product bits
                n_acc   = r_acc << r_shamt;
                n_cnt   = r_half;
                n_state = ata_pkg::MD_DIV;
            end
            ata_pkg::MD_DIV: begin
                n_acc = acc2;
                n_rem = rem2;
                if (r_cnt == '0) begin
                    n_state = ata_pkg::MD_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: n_state = ata_pkg::MD_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ata_pkg::MD_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_half  <= n_half;
        r_shamt <= n_shamt;
        r_a     <= n_a;
        r_b     <= n_b;
        r_c     <= n_c;
        r_acc   <= n_acc;
        r_rem   <= n_rem;
    end

    assign o_rsp.done   = (r_state == ata_pkg::MD_DONE);
    assign o_rsp.quot   = r_acc;
    assign o_rsp.rem_nz = |r_rem;

endmodule

// ===== dv/ata_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for audio_timeline_aligner_unit: tracks register writes, predicts the
// outcome of every accepted packet header and compares it with each result transfer.
// Depends on ata_pkg.
module ata_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ata_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ata_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  ata_pkg::t_in_item              i_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  ata_pkg::t_out_item             i_out,
    output int                             o_fail_count,
    output int                             o_outstanding,
    output logic [3:0][31:0]               o_status_hits
);
    import ata_pkg::*;

    localparam logic [63:0] TICKS       = 64'd10_000_000;
    localparam logic [63:0] SIGN        = 64'h8000_0000_0000_0000;

    logic [17:0]      rate_reg;
    logic [6:0]       frame_bytes;
    logic [63:0]      origin;
    logic [63:0]      position;
    logic             seeded;
    t_out_item        pending_outcomes [$];
    int               mismatch_total  = 0;
    int               outstanding     = 0;
    int               results_checked = 0;
    logic [3:0][31:0] status_hits     = '0;

    assign o_fail_count  = mismatch_total;
    assign o_outstanding = outstanding;
    assign o_status_hits = status_hits;

    task automatic flag_mismatch(input string what);
        mismatch_total++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                    results_checked, name, got, want));
    endtask

    function automatic logic later_than(input logic [63:0] a, input logic [63:0] b);
        return $signed(a) > $signed(b);
    endfunction

    // floor or ceil of ticks * rate / 1e7, saturating at 64 bits
    function automatic logic [63:0] frames_in(input logic [63:0] ticks, input logic round_up);
        logic [127:0] scaled;
        scaled = {64'd0, ticks} * {110'd0, rate_reg};
        if (round_up)
            scaled = scaled + {64'd0, TICKS} - 128'd1;
        scaled = scaled / {64'd0, TICKS};
        return (scaled[127:64] != '0) ? '1 : scaled[63:0];
    endfunction

    // move forward on the signed timeline, clamping at the top
    function automatic void advance_position(input logic [63:0] amount);
        logic [63:0] biased;
        biased   = position ^ SIGN;
        biased   = (amount > ~biased) ? '1 : biased + amount;
        position = biased ^ SIGN;
    endfunction

    function automatic t_out_item align_packet(input t_in_item pkt);
        t_out_item   res;
        t_status     verdict;
        logic [63:0] pt, fc, bc, rate, bpf;
        logic [63:0] span, gap_frames, lead, off, avail, frames;
        logic [63:0] silence, skip, wbytes;
        pt      = pkt.packet_time;
        fc      = {44'd0, pkt.frame_count};
        bc      = {38'd0, pkt.byte_count};
        rate    = {46'd0, rate_reg};
        bpf     = {57'd0, frame_bytes};
        verdict = ST_WRITTEN;
        silence = '0;
        skip    = '0;
        wbytes  = '0;
        if (fc == 0 || bc == 0) begin
            verdict = ST_EMPTY;
        end else begin
            if (!seeded) begin
                position = origin;
                seeded   = 1'b1;
            end
            if (rate == 0 || bpf == 0) begin
                verdict = ST_EMPTY;
            end else begin
                span = (fc * TICKS) / rate;
                if (!later_than(pt, position) && span <= position - pt) begin
                    verdict = ST_STALE;
                end else begin
                    if (later_than(pt, position)) begin
                        gap_frames = frames_in(pt - position, 1'b0);
                        silence    = (gap_frames > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : gap_frames;
                        advance_position((silence * TICKS) / rate);
                    end
                    if (later_than(position, pt)) begin
                        lead = frames_in(position - pt, 1'b1);
                        skip = (lead < fc) ? lead : fc;
                    end
                    off = skip * bpf;
                    if (skip >= fc || off >= bc) begin
                        verdict = ST_TRIMMED;
                        silence = '0;
                    end else begin
                        avail  = (fc - skip) * bpf;
                        wbytes = bc - off;
                        if (wbytes > avail)
                            wbytes = avail;
                        frames = wbytes / bpf;
                        advance_position((frames * TICKS) / rate);
                    end
                end
            end
        end
        res.status         = verdict;
        res.silence_frames = silence[31:0];
        res.skip_frames    = skip[19:0];
        res.write_bytes    = wbytes[25:0];
        res.timeline_next  = position;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            rate_reg    = RST_SAMPLE_RATE;
            frame_bytes = RST_BYTES_PER_FRAME;
            origin      = RST_TIMELINE_START;
            position    = '0;
            seeded      = 1'b0;
            pending_outcomes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SAMPLE_RATE:     rate_reg    = i_cfg_data[17:0];
                    CFG_BYTES_PER_FRAME: frame_bytes = i_cfg_data[6:0];
                    CFG_TIMELINE_START:  origin      = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_outcomes.size() == 0) begin
                    flag_mismatch($sformatf("result %0d arrived with no packet waiting",
                                            results_checked));
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("status", 64'(i_out.status), 64'(want.status));
                    check_field("silence_frames", 64'(i_out.silence_frames),
                                64'(want.silence_frames));
                    check_field("skip_frames", 64'(i_out.skip_frames), 64'(want.skip_frames));
                    check_field("write_bytes", 64'(i_out.write_bytes), 64'(want.write_bytes));
                    check_field("timeline_next", i_out.timeline_next, want.timeline_next);
                    status_hits[want.status] = status_hits[want.status] + 32'd1;
                end
                results_checked++;
            end
            if (i_in_valid && !i_in_stall)
                pending_outcomes.insert(pending_outcomes.size(), align_packet(i_in));
        end
        outstanding = pending_outcomes.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the audio_timeline_aligner_unit testbench: clock, reset, register writes and
// packet header stimulus with random idling; the verdict comes from ata_checker.
// Depends on ata_pkg, audio_timeline_aligner_unit and ata_checker.
module tb_top;
    import ata_pkg::*;

    localparam int          CYCLE_LIMIT = 2_000_000;
    localparam int          PHASES      = 9;
    localparam logic [63:0] TOP_TIME    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] BOTTOM_TIME = 64'h8000_0000_0000_0000;
    localparam logic signed [63:0] ORIGIN = -64'sd1_000_000_000_000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SAMPLE_RATE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_item             in_item   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_item;

    int                   fail_count;
    int                   outstanding;
    logic [3:0][31:0]     status_hits;

    logic                 calm          = 1'b0;
    int                   cycle_count   = 0;
    int                   packets_sent  = 0;
    int                   settings_used = 0;
    logic [17:0]          rate_now      = RST_SAMPLE_RATE;
    logic [6:0]           bpf_now       = RST_BYTES_PER_FRAME;
    logic signed [63:0]   seen_position = '0;
    logic signed [63:0]   stream_cursor = ORIGIN;

    logic [17:0] phase_rate [PHASES] = '{18'd44100, 18'd8000, 18'd192000, 18'd1,
                                         18'd262143, 18'd0, 18'd0, 18'd48000, 18'd96000};
    logic [6:0]  phase_bpf  [PHASES] = '{7'd2, 7'd1, 7'd64, 7'd8, 7'd127, 7'd0, 7'd4,
                                         7'd0, 7'd6};

    audio_timeline_aligner_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    ata_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in          (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out         (out_item),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_status_hits (status_hits)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, outstanding);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= !calm && ($urandom_range(99) < 18);

    // last position reported by the block; keeps the packet stream near the timeline
    always @(posedge clk)
        if (out_valid && !out_stall)
            seen_position <= out_item.timeline_next;

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic offer_packet(input t_in_item pkt);
        while (!calm && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= pkt;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        packets_sent++;
    endtask

    // drop valid and wait until every accepted packet has its result
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    task automatic place_packet(input logic [63:0] pt, input logic [19:0] fc,
                                input logic [25:0] bc);
        t_in_item pkt;
        pkt.packet_time = pt;
        pkt.frame_count = fc;
        pkt.byte_count  = bc;
        offer_packet(pkt);
        settle();
    endtask

    task automatic apply_setting(input logic [17:0] rate, input logic [6:0] bpf,
                                 input logic [63:0] origin_value);
        settle();
        write_reg(CFG_SAMPLE_RATE, 64'(rate));
        write_reg(CFG_BYTES_PER_FRAME, 64'(bpf));
        write_reg(CFG_TIMELINE_START, origin_value);
        rate_now = rate;
        bpf_now  = bpf;
        settings_used++;
    endtask

    // contiguous audio with jitter: mostly on time, some gaps, overlaps and repeats
    function automatic t_in_item stream_packet();
        t_in_item           pkt;
        logic [63:0]        fc, full, bc, span, reach;
        logic signed [63:0] pt;
        int unsigned        roll;
        fc = ($urandom_range(99) < 5) ? 64'($urandom_range(20'hFFFFF, 1))
                                      : 64'($urandom_range(2048, 1));
        span = (rate_now == 0) ? 64'd1000 : (fc * 64'd10_000_000) / rate_now;
        full = fc * bpf_now;
        roll = $urandom_range(99);
        if (roll < 70)
            bc = full;
        else if (roll < 85 && full > 1)
            bc = 64'($urandom_range(32'(full), 1));
        else
            bc = full + $urandom_range(500, 1);
        if (bc == 0)
            bc = 1;
        if (bc > 64'h3FF_FFFF)
            bc = 64'h3FF_FFFF;
        if (seen_position > stream_cursor)
            stream_cursor = seen_position;
        reach = span + span / 2 + 1;
        if (reach > 64'h7FFF_FFFF)
            reach = 64'h7FFF_FFFF;
        roll = $urandom_range(99);
        if (roll < 50)
            pt = stream_cursor;
        else if (roll < 70)
            pt = stream_cursor + $urandom_range(50000, 1);
        else if (roll < 90)
            pt = stream_cursor - $urandom_range(32'(reach), 1);
        else
            pt = stream_cursor + longint'($urandom) * $urandom_range(4096, 1);
        if (pt + $signed(span) > stream_cursor)
            stream_cursor = pt + $signed(span);
        pkt.packet_time = pt;
        pkt.frame_count = fc[19:0];
        pkt.byte_count  = bc[25:0];
        return pkt;
    endfunction

    initial begin
        t_in_item    pkt;
        logic [17:0] rate;
        logic [6:0]  bpf;
        logic [63:0] origin_value;
        int          count;
        int unsigned roll;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // only the last origin written before the first real packet seeds the position
        write_reg(CFG_TIMELINE_START, TOP_TIME);
        write_reg(CFG_TIMELINE_START, BOTTOM_TIME);
        write_reg(CFG_TIMELINE_START, ORIGIN);
        write_reg(CFG_SAMPLE_RATE, 64'd48000);
        write_reg(CFG_BYTES_PER_FRAME, 64'd4);
        rate_now = 18'd48000;
        bpf_now  = 7'd4;
        settings_used++;

        place_packet(64'd0, 20'd0, 26'h3FF_FFFF);
        place_packet(ORIGIN, 20'hF_FFFF, 26'd0);
        place_packet(ORIGIN, 20'd480, 26'd1920);
        place_packet(seen_position + 64'd12345, 20'd100, 26'd400);
        place_packet(seen_position - 64'd3000, 20'd200, 26'd800);
        place_packet(ORIGIN, 20'd10, 26'd40);
        place_packet(seen_position - 64'd100, 20'd1, 26'd4);
        place_packet(seen_position - 64'd300, 20'd10, 26'd4);
        place_packet(seen_position, 20'd100, 26'd123);
        place_packet(seen_position, 20'd50, 26'd1000);
        place_packet(seen_position + 64'd7, 20'hF_FFFF, 26'h3FF_FFFF);
        place_packet(BOTTOM_TIME, 20'd5, 26'd20);
        place_packet(seen_position + 64'h0100_0000_0000_0000, 20'd64, 26'd256);
        // packet ending exactly on the position, then one tick later
        place_packet(seen_position - 64'd10000, 20'd48, 26'd192);
        place_packet(seen_position - 64'd9999, 20'd48, 26'd192);
        place_packet(seen_position, 20'd3, 26'd11);

        for (int p = 0; p < PHASES; p++) begin
            rate = phase_rate[p];
            bpf  = phase_bpf[p];
            if (p == 5) begin
                rate = 18'($urandom_range(192000, 1));
                bpf  = 7'($urandom_range(64, 1));
            end
            case (p % 3)
                0:       origin_value = TOP_TIME;
                1:       origin_value = BOTTOM_TIME;
                default: origin_value = {$urandom, $urandom};
            endcase
            apply_setting(rate, bpf, origin_value);
            calm  = (p == 1);
            count = (rate == 0 || bpf == 0) ? 25 : 230;
            for (int k = 0; k < count; k++) begin
                roll = $urandom_range(99);
                if (roll < 8) begin
                    pkt.packet_time = {$urandom, $urandom};
                    pkt.frame_count = 20'($urandom);
                    pkt.byte_count  = 26'($urandom);
                    case ($urandom_range(2))
                        0:       pkt.frame_count = '0;
                        1:       pkt.byte_count  = '0;
                        default: begin
                            pkt.frame_count = '0;
                            pkt.byte_count  = '0;
                        end
                    endcase
                end else if (roll < 18) begin
                    pkt.packet_time = {$urandom, $urandom};
                    pkt.frame_count = 20'($urandom);
                    pkt.byte_count  = 26'($urandom);
                end else begin
                    pkt = stream_packet();
                end
                offer_packet(pkt);
            end
        end
        calm = 1'b0;

        // climb to the top of the timeline with saturated gaps, then clamp there
        apply_setting(18'd1, 7'd1, 64'd0);
        for (int k = 0; k < 240; k++) begin
            pkt.packet_time = TOP_TIME;
            pkt.frame_count = 20'($urandom_range(1000, 1));
            pkt.byte_count  = 26'($urandom_range(2000, 1));
            offer_packet(pkt);
        end
        settle();
        repeat (200) @(posedge clk);

        $display("Sent %0d packet headers over %0d register settings, zero rate and frame",
                 packets_sent, settings_used);
        $display("size included; results: %0d written, %0d empty, %0d stale, %0d trimmed.",
                 status_hits[ST_WRITTEN], status_hits[ST_EMPTY], status_hits[ST_STALE],
                 status_hits[ST_TRIMMED]);
        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== audio_timeline_aligner_unit.f =====
hw/rtl/ata_pkg.sv
hw/rtl/ata_muldiv.sv
hw/rtl/audio_timeline_aligner_unit.sv
dv/ata_checker.sv
dv/tb_top.sv
